@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);

// Shorthand for the usual clk / arst_n pair.
`define GCS_ASSERT(lbl, prop, msg) \
	`ASSERT_CLK_RST(lbl, clk, arst_n, prop, msg)

`endif

@@ rtl/gcs_pkg.sv @@
`timescale 1ns / 1ps

package gcs_pkg;

	localparam int PIX_W = 8;
	// |(p - min) * (new_max - new_min) + (max - min) / 2| stays below 2^17
	localparam int NUM_W = 17;
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [1:0] FUNC_MEASURE = 2'd1;
	localparam logic [1:0] FUNC_SCALE   = 2'd2;

	localparam logic [1:0] REG_NEW_MIN = 2'd0;
	localparam logic [1:0] REG_NEW_MAX = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [PIX_W-1:0] divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_stat_t;

endpackage

@@ rtl/gcs_div.sv @@
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module gcs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gcs_pkg::div_ctrl_t ctrl,
	output gcs_pkg::div_stat_t stat
);
	import gcs_pkg::*;

	logic [NUM_W-1:0] dq_q;   // dividend shifts out, quotient shifts in
	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [PIX_W:0]   rem_sh;
	logic [PIX_W:0]   rem_sub;
	logic             ge;

	always_comb begin
		rem_sh  = {rem_q, dq_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		ge      = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dq_q  <= ctrl.dividend;
			rem_q <= '0;
			dvs_q <= ctrl.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[PIX_W-1:0] : rem_sh[PIX_W-1:0];
			dq_q  <= {dq_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.quotient = dq_q;

endmodule

@@ rtl/gray_contrast_stretch.sv @@
// Min/max contrast stretch of 8-bit gray pixels.
// Input channel (in_valid / in_stall, func, pixel): func 0 clears the stored
// min/max, func 1 folds pixel into them, func 2 rescales pixel, func 3 is
// dropped. Clear and measure transfers give no result.
// A scale transfer gives one result on the output channel (out_valid /
// out_stall, scaled_pixel): the numerator is formed, the restoring divider
// yields one quotient bit per cycle, the quotient is sign-fixed and offset
// into a result register, then the result enters the output register.
// A flat or empty measurement skips the divider and gives new_min.
// in_stall is high while a scale item is in flight. An unclaimed result
// sits in the output register while the next transfer is taken; a finished
// scale waits for the register to free up if the receiver stalls.
// Config port (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 new_min,
// index 1 new_max, others ignored; always ready.
// Reset: new_min 0, new_max 255, nothing measured, output empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gray_contrast_stretch (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] pixel,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] scaled_pixel,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import gcs_pkg::*;

	st_t              state_q, state_d;
	logic [PIX_W-1:0] new_min_q, new_max_q;
	logic [PIX_W-1:0] seen_min_q, seen_max_q;
	logic             any_seen_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_q;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] res_q;
	logic             neg_q;

	logic             in_xfer, cfg_xfer, flat, load_out;
	logic signed [PIX_W:0]   diff, ndiff;
	logic signed [2*PIX_W+1:0] prod, num, num_neg;
	logic [PIX_W-1:0] odiff;
	logic [PIX_W-1:0] q8, res_d;
	div_ctrl_t        div_ctrl;
	div_stat_t        div_stat;

	assign in_xfer  = in_valid && !in_stall;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign flat     = !any_seen_q || (seen_max_q <= seen_min_q);

	// numerator: (p - min) * (new_max - new_min) + (max - min) / 2
	always_comb begin
		diff    = $signed({1'b0, pix_q}) - $signed({1'b0, seen_min_q});
		ndiff   = $signed({1'b0, new_max_q}) - $signed({1'b0, new_min_q});
		odiff   = seen_max_q - seen_min_q;
		prod    = diff * ndiff;
		num     = prod + $signed({{(PIX_W+3){1'b0}}, odiff[PIX_W-1:1]});
		num_neg = -num;
	end

	// divide magnitudes, restore the sign on the quotient (truncates to zero)
	always_comb begin
		q8    = div_stat.quotient[PIX_W-1:0];
		res_d = (neg_q ? (~q8 + 1'b1) : q8) + new_min_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && func == FUNC_SCALE)
					state_d = flat ? ST_DONE : ST_MUL;
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_stat.done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall          = (state_q != ST_IDLE);
		load_out          = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		div_ctrl.start    = (state_q == ST_MUL);
		div_ctrl.dividend = num[2*PIX_W+1] ? num_neg[NUM_W-1:0] : num[NUM_W-1:0];
		div_ctrl.divisor  = odiff;
	end

	gcs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (div_ctrl),
		.stat  (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			new_min_q   <= 8'd0;
			new_max_q   <= 8'd255;
			seen_min_q  <= 8'd255;
			seen_max_q  <= 8'd0;
			any_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_xfer) begin
				if (cfg_index == REG_NEW_MIN)
					new_min_q <= cfg_data;
				else if (cfg_index == REG_NEW_MAX)
					new_max_q <= cfg_data;
			end
			if (in_xfer) begin
				case (func)
					FUNC_CLEAR: begin
						seen_min_q <= 8'd255;
						seen_max_q <= 8'd0;
						any_seen_q <= 1'b0;
					end
					FUNC_MEASURE: begin
						if (pixel < seen_min_q)
							seen_min_q <= pixel;
						if (pixel > seen_max_q)
							seen_max_q <= pixel;
						any_seen_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_q <= pixel;
			res_q <= new_min_q;
		end
		if (state_q == ST_MUL)
			neg_q <= num[2*PIX_W+1];
		if (state_q == ST_DIV && div_stat.done)
			res_q <= res_d;
		if (load_out)
			out_q <= res_q;
	end

	assign out_valid    = out_valid_q;
	assign scaled_pixel = out_q;
	assign cfg_ready    = 1'b1;

	`GCS_ASSERT(a_out_from_done,
		$rose(out_valid_q) |-> $past(state_q == ST_DONE),
		"result without finished item")
	`GCS_ASSERT(a_div_done_in_div,
		div_stat.done |-> (state_q == ST_DIV),
		"divider finished outside divide phase")
	`GCS_ASSERT(a_div_busy_in_div,
		div_stat.busy |-> (state_q == ST_DIV),
		"divider busy outside divide phase")
	`GCS_ASSERT(a_flat_gives_min,
		(in_xfer && func == FUNC_SCALE && flat) |=>
			(state_q == ST_DONE && res_q == $past(new_min_q)),
		"flat measurement must give new_min")

endmodule

@@ tb/gray_contrast_stretch_tb.sv @@
`timescale 1ns / 1ps

module gray_contrast_stretch_tb;
	import gcs_pkg::*;

	// func code the block drops without a trace
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// extra settle time that covers anything still in flight
	localparam int SETTLE_CYCLES = 30;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [7:0] pixel;
		logic [7:0] value;
	} scaled_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] func = FUNC_CLEAR;
	logic [7:0] pixel = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] scaled_pixel;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_NEW_MIN;
	logic [7:0] cfg_data = 8'd0;

	// shadow of the block: target range registers and measured extremes
	logic [7:0] target_lo = 8'd0;
	logic [7:0] target_hi = 8'd255;
	logic [7:0] darkest = 8'd255;
	logic [7:0] brightest = 8'd0;
	logic       measured = 1'b0;

	scaled_t    scaled_q[$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         pixels_sent = 0;

	gray_contrast_stretch uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scaled_pixel (scaled_pixel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [7:0] stretch_value(input logic [7:0] p);
		int span_in;
		int span_out;
		int num;
		int q;
		if (!measured || brightest <= darkest)
			return target_lo;
		span_in = int'(brightest) - int'(darkest);
		span_out = int'(target_hi) - int'(target_lo);
		num = (int'(p) - int'(darkest)) * span_out + span_in / 2;
		// SV int division truncates toward zero, the low byte is what the block keeps
		q = num / span_in + int'(target_lo);
		return q[7:0];
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		scaled_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (scaled_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing outstanding", scaled_pixel));
			end else begin
				want = scaled_q.pop_front();
				if (scaled_pixel !== want.value)
					report_mismatch($sformatf("pixel %0d scaled_pixel got %0d want %0d",
						want.pixel, scaled_pixel, want.value));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] f, input logic [7:0] p);
		scaled_t item;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		pixel <= p;
		do @(posedge clk); while (in_stall);
		// the transfer has been taken by this point
		case (f)
			FUNC_CLEAR: begin
				darkest = 8'd255;
				brightest = 8'd0;
				measured = 1'b0;
			end
			FUNC_MEASURE: begin
				if (p < darkest)
					darkest = p;
				if (p > brightest)
					brightest = p;
				measured = 1'b1;
			end
			FUNC_SCALE: begin
				item.pixel = p;
				item.value = stretch_value(p);
				scaled_q.push_back(item);
			end
			default: ;
		endcase
		if (f != FUNC_UNUSED)
			pixels_sent++;
	endtask

	// drop valid and wait for every scale result, then for extra_cycles more
	task automatic settle(input int extra_cycles);
		in_valid <= 1'b0;
		while (scaled_q.size() != 0)
			@(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		settle(SETTLE_CYCLES);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_NEW_MIN)
			target_lo = val;
		else if (idx == REG_NEW_MAX)
			target_hi = val;
	endtask

	task automatic test_empty_measure();
		send_item(FUNC_SCALE, 8'd0);
		send_item(FUNC_SCALE, 8'd255);
		send_item(FUNC_CLEAR, 8'h5A);
		send_item(FUNC_SCALE, 8'hA5);
	endtask

	task automatic test_flat_range();
		send_item(FUNC_MEASURE, 8'd77);
		send_item(FUNC_MEASURE, 8'd77);
		send_item(FUNC_SCALE, 8'd77);
		send_item(FUNC_SCALE, 8'd0);
	endtask

	task automatic test_full_range();
		send_item(FUNC_CLEAR, 8'd0);
		send_item(FUNC_MEASURE, 8'd0);
		send_item(FUNC_MEASURE, 8'd255);
		send_item(FUNC_SCALE, 8'd0);
		send_item(FUNC_SCALE, 8'd255);
		send_item(FUNC_SCALE, 8'd128);
	endtask

	task automatic test_reversed_range();
		write_reg(REG_NEW_MIN, 8'd255);
		write_reg(REG_NEW_MAX, 8'd0);
		send_item(FUNC_SCALE, 8'd0);
		send_item(FUNC_SCALE, 8'd255);
		send_item(FUNC_SCALE, 8'd100);
	endtask

	task automatic test_outside_range();
		write_reg(REG_NEW_MIN, 8'd16);
		write_reg(REG_NEW_MAX, 8'd235);
		send_item(FUNC_CLEAR, 8'd255);
		send_item(FUNC_MEASURE, 8'd100);
		send_item(FUNC_MEASURE, 8'd150);
		send_item(FUNC_SCALE, 8'd0);
		send_item(FUNC_SCALE, 8'd255);
	endtask

	task automatic test_unused_func();
		send_item(FUNC_UNUSED, 8'd255);
		send_item(FUNC_UNUSED, 8'd0);
		send_item(FUNC_SCALE, 8'd200);
	endtask

	// frames of register writes, clear, measure pass, scale pass with some noise mixed in
	task automatic test_random_frames(input int send_pct, input int recv_pct, input int quota);
		int start_count;
		int lo;
		int hi;
		int span;
		int n;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start_count = pixels_sent;
		while (pixels_sent - start_count < quota) begin
			if ($urandom_range(3) == 0) begin
				write_reg(REG_NEW_MIN, pick_level());
				if ($urandom_range(1))
					write_reg(REG_NEW_MAX, pick_level());
			end else if ($urandom_range(7) == 0) begin
				settle(0);
			end
			// skipping the clear carries the old extremes into this frame
			if ($urandom_range(9) != 0)
				send_item(FUNC_CLEAR, 8'($urandom_range(255)));
			lo = $urandom_range(255);
			case ($urandom_range(3))
				0: span = 0;
				1: span = $urandom_range(8, 1);
				default: span = $urandom_range(255);
			endcase
			hi = (lo + span > 255) ? 255 : lo + span;
			n = $urandom_range(10);
			repeat (n) begin
				if ($urandom_range(11) == 0)
					send_item(FUNC_UNUSED, 8'($urandom_range(255)));
				send_item(FUNC_MEASURE, 8'($urandom_range(hi, lo)));
			end
			n = $urandom_range(10, 1);
			repeat (n) begin
				case ($urandom_range(15))
					0: send_item(FUNC_UNUSED, 8'($urandom_range(255)));
					1: send_item(FUNC_MEASURE, 8'($urandom_range(255)));
					default: ;
				endcase
				if ($urandom_range(3) == 0)
					send_item(FUNC_SCALE, 8'($urandom_range(255)));
				else
					send_item(FUNC_SCALE, 8'($urandom_range(hi, lo)));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_measure();
		test_flat_range();
		test_full_range();
		test_reversed_range();
		test_outside_range();
		test_unused_func();
		test_random_frames(8, 59, 370);
		test_random_frames(59, 8, 370);
		test_random_frames(0, 0, 360);
		settle(SETTLE_CYCLES);
		if (scaled_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", scaled_q.size()));
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gcs_pkg.sv
rtl/gcs_div.sv
rtl/gray_contrast_stretch.sv
tb/gray_contrast_stretch_tb.sv
